FILE: rtl/core/brac_pkg.sv
// brac_pkg: shared types, constants and saturating add for the rule attack chain
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package brac_pkg;

    localparam int NUM_RULES_DEF = 16;
    localparam int CAT_CODES     = 32;
    // categorical codes must also fit the 32-bit code mask
    localparam int CAT_LIM       = (CAT_CODES < 32) ? CAT_CODES : 32;
    localparam int MAX_STEPS     = 63;
    localparam int STEP_W        = 6;
    localparam int VAL_W         = 32;
    localparam int FEAT_W        = 8;
    localparam int SLOT_W        = 4;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic {
        FUNC_LOAD   = 1'b0,
        FUNC_ATTACK = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_OVER  = 2'd1,
        ST_TRUNC = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [FEAT_W-1:0]       feature;
        logic                    numerical;
        logic signed [VAL_W-1:0] low;
        logic signed [VAL_W-1:0] high;
        logic signed [VAL_W-1:0] post;
        logic signed [VAL_W-1:0] cost;
        logic [VAL_W-1:0]        codes;
    } t_rule;

    typedef struct packed {
        logic    load_wr;
        logic    start;
        logic    take;
        logic    emit;
        logic    last;
        t_status status;
        logic    advance;
    } t_cmd;

    typedef struct packed {
        logic over;
        logic match;
        logic out_free;
    } t_sts;

    function automatic logic signed [VAL_W-1:0] sat_add(
        input logic signed [VAL_W-1:0] a,
        input logic signed [VAL_W-1:0] b
    );
        logic [VAL_W:0] s;
        s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
        if (s[VAL_W] != s[VAL_W-1]) begin
            return s[VAL_W] ? VAL_MIN : VAL_MAX;
        end
        return s[VAL_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/brac_ram.sv
// brac_ram: generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module brac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/core/brac_ctrl.sv
// brac_ctrl: state machine that sequences loads, slot scans and result beats
// depends on brac_pkg
`default_nettype none

module brac_ctrl #(
    parameter int NUM_RULES = brac_pkg::NUM_RULES_DEF,
    parameter int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire logic              i_func,
    output logic                   o_in_ready,
    output brac_pkg::t_cmd         o_cmd,
    output logic [IDX_W-1:0]       o_rd_addr,
    input  wire brac_pkg::t_sts    i_sts
);
    import brac_pkg::*;

    localparam logic [IDX_W:0] LAST_IDX = (IDX_W+1)'(NUM_RULES - 1);
    localparam logic [IDX_W:0] NUM_IDX  = (IDX_W+1)'(NUM_RULES);
    localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(MAX_STEPS);

    t_state            r_state, n_state;
    logic [IDX_W:0]    r_idx, n_idx;
    logic              r_pend, n_pend;
    logic              r_pend_end, n_pend_end;
    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_found, n_found;
    logic              r_over, n_over;
    logic              hit;
    logic              final_beat;

    assign hit        = r_pend && i_sts.match;
    assign final_beat = r_over || !r_found || (r_steps == STEP_LIM);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_idx      <= '0;
            r_pend     <= 1'b0;
            r_pend_end <= 1'b0;
            r_steps    <= '0;
            r_found    <= 1'b0;
            r_over     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_pend     <= n_pend;
            r_pend_end <= n_pend_end;
            r_steps    <= n_steps;
            r_found    <= n_found;
            r_over     <= n_over;
        end
    end

    // next state and counters
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_pend     = r_pend;
        n_pend_end = r_pend_end;
        n_steps    = r_steps;
        n_found    = r_found;
        n_over     = r_over;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid && (i_func == FUNC_ATTACK)) begin
                    n_state = S_CHECK;
                    n_steps = '0;
                end
            end
            S_CHECK: begin
                n_over  = i_sts.over;
                n_found = 1'b0;
                n_idx   = '0;
                n_pend  = 1'b0;
                n_state = i_sts.over ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                // one slot read issued per cycle, evaluated in the cycle after its read
                if (r_idx < NUM_IDX) begin
                    n_pend     = 1'b1;
                    n_pend_end = (r_idx == LAST_IDX);
                    n_idx      = r_idx + 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (hit) begin
                    n_found = 1'b1;
                    n_state = S_EMIT;
                end else if (r_pend && r_pend_end) begin
                    n_found = 1'b0;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    if (final_beat) begin
                        n_state = S_IDLE;
                    end else begin
                        n_steps = r_steps + 1'b1;
                        n_idx   = '0;
                        n_pend  = 1'b0;
                        n_found = 1'b0;
                        n_state = S_SCAN;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // commands to the datapath
    always_comb begin
        o_in_ready  = 1'b0;
        o_cmd       = '0;
        o_cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_wr = i_in_valid && (i_func == FUNC_LOAD);
                o_cmd.start   = i_in_valid && (i_func == FUNC_ATTACK);
            end
            S_CHECK: begin
            end
            S_SCAN: begin
                o_cmd.take = hit;
            end
            S_EMIT: begin
                o_cmd.emit    = i_sts.out_free;
                o_cmd.last    = final_beat;
                o_cmd.advance = i_sts.out_free && !final_beat;
                if (r_over) begin
                    o_cmd.status = ST_OVER;
                end else if (r_found && (r_steps == STEP_LIM)) begin
                    o_cmd.status = ST_TRUNC;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_rd_addr = r_idx[IDX_W-1:0];

endmodule

`default_nettype wire

FILE: rtl/core/brac_dp.sv
// brac_dp: rule table, walk registers, rule match logic and output register
// depends on brac_pkg and brac_ram
`default_nettype none

module brac_dp #(
    parameter int NUM_RULES = brac_pkg::NUM_RULES_DEF,
    parameter int IDX_W     = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire brac_pkg::t_cmd                       i_cmd,
    input  wire logic [IDX_W-1:0]                     i_rd_addr,
    output brac_pkg::t_sts                            o_sts,
    input  wire logic                                 i_cfg_we,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_cfg_data,
    input  wire logic [brac_pkg::SLOT_W-1:0]          i_rule_slot,
    input  wire logic [brac_pkg::FEAT_W-1:0]          i_rule_feature,
    input  wire logic                                 i_rule_numerical,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_low,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_high,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_post,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_cost,
    input  wire logic [brac_pkg::VAL_W-1:0]           i_rule_codes,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_attack_value,
    input  wire logic [brac_pkg::FEAT_W-1:0]          i_attack_feature,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_start_cost,
    input  wire logic                                 i_out_ready,
    output logic                                      o_out_valid,
    output logic signed [brac_pkg::VAL_W-1:0]         o_out_value,
    output logic signed [brac_pkg::VAL_W-1:0]         o_out_cost,
    output logic                                      o_out_last,
    output logic [1:0]                                o_out_status
);
    import brac_pkg::*;

    logic signed [VAL_W-1:0] r_budget;
    logic [NUM_RULES-1:0]    r_slot_valid;
    logic                    r_ev_ok;
    logic signed [VAL_W-1:0] r_val, r_cost;
    logic [FEAT_W-1:0]       r_feat;
    logic signed [VAL_W-1:0] r_nval, r_ncost;
    logic                    r_o_valid;
    logic signed [VAL_W-1:0] r_o_value, r_o_cost;
    logic                    r_o_last;
    t_status                 r_o_status;

    t_rule                   wr_rule;
    t_rule                   rd_rule;
    logic [$bits(t_rule)-1:0] rd_bits;
    logic                    slot_in_range;
    logic                    wr_en;
    logic [IDX_W-1:0]        wr_addr;
    logic signed [VAL_W-1:0] cand_val, cand_cost;
    logic                    code_hit, range_hit, cost_ok;

    assign slot_in_range = (32'(i_rule_slot) < 32'(NUM_RULES));
    assign wr_en         = i_cmd.load_wr && slot_in_range;
    assign wr_addr       = IDX_W'(i_rule_slot);

    always_comb begin
        wr_rule.feature   = i_rule_feature;
        wr_rule.numerical = i_rule_numerical;
        wr_rule.low       = i_rule_low;
        wr_rule.high      = i_rule_high;
        wr_rule.post      = i_rule_post;
        wr_rule.cost      = i_rule_cost;
        wr_rule.codes     = i_rule_codes;
    end

    brac_ram #(
        .WIDTH ($bits(t_rule)),
        .DEPTH (NUM_RULES),
        .AW    (IDX_W)
    ) u_rules (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_rule),
        .i_raddr (i_rd_addr),
        .o_rdata (rd_bits)
    );

    assign rd_rule = t_rule'(rd_bits);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_budget     <= VAL_MAX;
            r_slot_valid <= '0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_budget <= i_cfg_data;
            end
            if (wr_en) begin
                r_slot_valid[wr_addr] <= 1'b1;
            end
            if (i_cmd.emit) begin
                r_o_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_ev_ok <= r_slot_valid[i_rd_addr];
        if (i_cmd.start) begin
            r_val  <= i_attack_value;
            r_cost <= i_start_cost;
            r_feat <= i_attack_feature;
        end else if (i_cmd.advance) begin
            r_val  <= r_nval;
            r_cost <= r_ncost;
        end
        if (i_cmd.take) begin
            r_nval  <= cand_val;
            r_ncost <= cand_cost;
        end
        if (i_cmd.emit) begin
            r_o_value  <= r_val;
            r_o_cost   <= r_cost;
            r_o_last   <= i_cmd.last;
            r_o_status <= i_cmd.status;
        end
    end

    // match of the slot read in the previous cycle against the walk state
    always_comb begin
        cand_cost = sat_add(r_cost, rd_rule.cost);
        cand_val  = rd_rule.numerical ? sat_add(r_val, rd_rule.post) : rd_rule.post;
        cost_ok   = !(cand_cost > r_budget);
        range_hit = (r_val >= rd_rule.low) && (r_val <= rd_rule.high);
        code_hit  = !r_val[VAL_W-1] && ($unsigned(r_val) < 32'(CAT_LIM))
                    && rd_rule.codes[r_val[4:0]];
    end

    always_comb begin
        o_sts.over     = (r_cost > r_budget);
        o_sts.match    = r_ev_ok && (rd_rule.feature == r_feat) && cost_ok
                         && (rd_rule.numerical ? range_hit : code_hit);
        o_sts.out_free = !r_o_valid || i_out_ready;
    end

    assign o_out_valid  = r_o_valid;
    assign o_out_value  = r_o_value;
    assign o_out_cost   = r_o_cost;
    assign o_out_last   = r_o_last;
    assign o_out_status = r_o_status;

endmodule

`default_nettype wire

FILE: rtl/core/budgeted_rule_attack_chain.sv
// budgeted_rule_attack_chain: top level joining controller and datapath
// depends on brac_pkg, brac_ctrl, brac_dp, brac_ram
//
// usage
//   input channel (i_in_valid / o_in_ready): i_func = 0 writes rule slot
//   i_rule_slot (slots at or above NUM_RULES are dropped), no result.
//   i_func = 1 attacks i_attack_value of i_attack_feature from i_start_cost.
//   output channel (o_out_valid / i_out_ready): one beat per value of the walk,
//   starting with the input value; o_out_last marks the final beat. the user must
//   write budget via i_cfg_we / i_cfg_data only while the block idles (not enforced).
// timing
//   an attack passes a budget check before its first slot scan, or goes straight
//   to its beat when over budget; each scan reads the rule RAM one slot per cycle
//   and stops at the first match or after the last slot, and the emit state then
//   hands the beat to the output register. one item at a time: the next item is
//   taken once the final beat sits in the output register.
// reset and stall
//   reset clears all slot valid bits, sets budget to the largest value and
//   empties the output register. a stalled receiver holds the beat and the
//   walk waits; no beat is dropped.
`default_nettype none

module budgeted_rule_attack_chain #(
    parameter int NUM_RULES = brac_pkg::NUM_RULES_DEF
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_we,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_cfg_data,
    input  wire logic                                 i_in_valid,
    output logic                                      o_in_ready,
    input  wire logic                                 i_func,
    input  wire logic [brac_pkg::SLOT_W-1:0]          i_rule_slot,
    input  wire logic [brac_pkg::FEAT_W-1:0]          i_rule_feature,
    input  wire logic                                 i_rule_numerical,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_low,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_high,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_post,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_rule_cost,
    input  wire logic [brac_pkg::VAL_W-1:0]           i_rule_codes,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_attack_value,
    input  wire logic [brac_pkg::FEAT_W-1:0]          i_attack_feature,
    input  wire logic signed [brac_pkg::VAL_W-1:0]    i_start_cost,
    output logic                                      o_out_valid,
    input  wire logic                                 i_out_ready,
    output logic signed [brac_pkg::VAL_W-1:0]         o_out_value,
    output logic signed [brac_pkg::VAL_W-1:0]         o_out_cost,
    output logic                                      o_out_last,
    output logic [1:0]                                o_out_status
);
    import brac_pkg::*;

    localparam int IDX_W = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;

    t_cmd             cmd;
    t_sts             sts;
    logic [IDX_W-1:0] rd_addr;

    brac_ctrl #(
        .NUM_RULES (NUM_RULES),
        .IDX_W     (IDX_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_func     (i_func),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd),
        .o_rd_addr  (rd_addr),
        .i_sts      (sts)
    );

    brac_dp #(
        .NUM_RULES (NUM_RULES),
        .IDX_W     (IDX_W)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .i_rd_addr        (rd_addr),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_rule_slot      (i_rule_slot),
        .i_rule_feature   (i_rule_feature),
        .i_rule_numerical (i_rule_numerical),
        .i_rule_low       (i_rule_low),
        .i_rule_high      (i_rule_high),
        .i_rule_post      (i_rule_post),
        .i_rule_cost      (i_rule_cost),
        .i_rule_codes     (i_rule_codes),
        .i_attack_value   (i_attack_value),
        .i_attack_feature (i_attack_feature),
        .i_start_cost     (i_start_cost),
        .i_out_ready      (i_out_ready),
        .o_out_valid      (o_out_valid),
        .o_out_value      (o_out_value),
        .o_out_cost       (o_out_cost),
        .o_out_last       (o_out_last),
        .o_out_status     (o_out_status)
    );

endmodule

`default_nettype wire

FILE: rtl/core/brac_checker.sv
// brac_checker: port-level assertions for the rule attack chain, bound to the top
// depends on brac_pkg
`default_nettype none

module brac_checker (
    input wire logic                              i_clk,
    input wire logic                              i_rst_n,
    input wire logic                              i_in_valid,
    input wire logic                              o_in_ready,
    input wire logic                              i_func,
    input wire logic                              o_out_valid,
    input wire logic                              i_out_ready,
    input wire logic [brac_pkg::VAL_W-1:0]        o_out_value,
    input wire logic [brac_pkg::VAL_W-1:0]        o_out_cost,
    input wire logic                              o_out_last,
    input wire logic [1:0]                        o_out_status
);
    import brac_pkg::*;

    // a stalled beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_valid && $stable(o_out_value) && $stable(o_out_cost)
            && $stable(o_out_last) && $stable(o_out_status))
        else $error("output beat changed while stalled");

    // over budget and truncation only ever end a run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_status != ST_OK) |-> o_out_last)
        else $error("error status on a beat that is not last");

    // an accepted attack closes the input as the walk begins
    a_busy_after_attack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_func == FUNC_ATTACK) |=> !o_in_ready)
        else $error("input reopened right after an attack beat");

endmodule

bind budgeted_rule_attack_chain brac_checker u_brac_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_func       (i_func),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_out_value  (o_out_value),
    .o_out_cost   (o_out_cost),
    .o_out_last   (o_out_last),
    .o_out_status (o_out_status)
);

`default_nettype wire
